// ===== sv/psd_pkg.sv =====
package psd_pkg;

   localparam int MaxInsertedDefault = 31;
   localparam int CoordWidth = 32;
   localparam int FaceWidth = 3;
   localparam int ReqDataWidth = 200;   // 6*32 + 3 = 195, padded to bytes
   localparam int RspDataWidth = 200;   // 6*32 + 3 = 195, padded to bytes
   localparam int RspPayloadWidth = 195;

   localparam int SqWidth = 68;         // sum of three 33-bit squares
   localparam int RootWidth = 36;
   localparam int RootSteps = SqWidth / 2;   // one root bit per pair of sum bits
   localparam int DiffWidth = 33;
   localparam int ProdWidth = 39;       // 33-bit diff times 6-bit j
   localparam int DivStepsN = 36;       // quotient bits for dist/spacing
   localparam int DivStepsLerp = ProdWidth;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_COUNT,
      ST_LERP_MUL,
      ST_LERP_DIV,
      ST_EMIT_INS,
      ST_EMIT_LAST
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [ProdWidth-1:0] dividend;
      logic [ProdWidth-1:0] divisor;
      logic [5:0]           steps;
   } div_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [ProdWidth-1:0] quotient;
   } div_sts_type;

endpackage

// ===== sv/psd_divider.sv =====
module psd_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  psd_pkg::div_cmd_type cmd,
   output psd_pkg::div_sts_type sts
);
   import psd_pkg::*;

   logic [ProdWidth-1:0] quot_ff, quot_in;
   logic [ProdWidth-1:0] rem_ff, rem_in;
   logic [ProdWidth-1:0] dsr_ff, dsr_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [ProdWidth:0]   trial;

   // restoring division, one quotient bit per cycle, MSB first
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (cmd.start) begin
         quot_in = cmd.dividend << (6'(ProdWidth) - cmd.steps);
         rem_in  = '0;
         dsr_in  = cmd.divisor;
         cnt_in  = cmd.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quot_ff[ProdWidth-1]} - {1'b0, dsr_ff};
         if (!trial[ProdWidth]) begin
            rem_in  = trial[ProdWidth-1:0];
            quot_in = {quot_ff[ProdWidth-2:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[ProdWidth-2:0], quot_ff[ProdWidth-1]};
            quot_in = {quot_ff[ProdWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      cnt_ff  <= cnt_in;
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quot_ff;

endmodule

// ===== sv/polyline_segment_densifier_unit.sv =====
// Polyline resampler for well-path intersection points.
// req_ channel: one point per request; rsp_ channel: the points it causes,
// inserted points (each twice) then the incoming point with rsp_tlast high.
// csr_wr_en/csr_wr_data write max_spacing (zero: pass every point through).
// A point passed through (first point, no previous point, zero spacing) has its
// result valid the cycle after acceptance.
// Any other point computes three squares (one 33x33 multiplier), a
// shift-and-subtract square root and one compare; with no insertion the
// compare leads straight to its result. With insertion a count division
// runs first, then each inserted point takes five multiplies and five 39-step
// divisions on the shared bit-serial divider plus its two results.
// req_tready is low while a point is in work; one request at a time.
// A stalled rsp_tready holds the current result and the sequencer.
// Reset (synchronous) clears max_spacing and the previous point.
module polyline_segment_densifier_unit #(
   parameter int MaxInserted = psd_pkg::MaxInsertedDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [31:0]                       csr_wr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pos_x, pos_y, pos_z, depth_md, depth_tvd, cell_index, face_code, zero pad
   input  logic [psd_pkg::ReqDataWidth-1:0]  req_tdata,
   input  logic                              req_tuser,   // first_point
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_x, out_y, out_z, out_md, out_tvd, out_cell, out_face, zero pad
   output logic [psd_pkg::RspDataWidth-1:0]  rsp_tdata,
   output logic                              rsp_tuser,   // is_inserted
   output logic                              rsp_tlast    // last_of_run
);
   import psd_pkg::*;

   localparam int CntW = $clog2(MaxInserted + 2);

   state_type state_ff, state_in;
   logic [31:0] spacing_ff;
   logic        have_prev_ff;
   logic [31:0] prev_ff [5];
   logic [31:0] cur_ff [5];
   logic [31:0] cell_ff;
   logic [2:0]  face_ff;
   logic [31:0] ipt_ff [5], ipt_in [5];
   logic [SqWidth-1:0]   sum_ff, sum_in;
   logic [RootWidth-1:0] root_ff, root_in;
   logic [RootWidth+1:0] rem_ff, rem_in;
   logic [5:0]  step_ff, step_in;      // square/multiply phase or root bit index
   logic [CntW-1:0] n_ff, n_in, j_ff, j_in;
   logic [2:0]  comp_ff, comp_in;
   logic        dup_ff, dup_in;
   logic        busy_div_ff, busy_div_in;
   logic [ProdWidth-1:0] prod_ff, prod_in;
   logic        neg_ff, neg_in;
   logic [65:0] mul_ff;
   logic [32:0] mul_a, mul_b;
   logic [DiffWidth-1:0] diff;
   div_cmd_type div_cmd;
   div_sts_type div_sts;

   // multiplier operand magnitude, root step terms and low quotient bits
   logic [DiffWidth-1:0] mag_d;
   logic [RootWidth+1:0] rem_shift;
   logic [RootWidth+1:0] root_trial;
   logic [31:0] q_mag;

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
   end

   psd_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   always_comb begin
      diff  = {cur_ff[comp_ff][31] & (comp_ff < 3'd3), cur_ff[comp_ff]}
            - {prev_ff[comp_ff][31] & (comp_ff < 3'd3), prev_ff[comp_ff]};
      mag_d = diff[DiffWidth-1] ? -diff : diff;
      // bring down the next two bits of the sum
      rem_shift  = {rem_ff[RootWidth-1:0], sum_ff[SqWidth-1 -: 2]};
      root_trial = {root_ff, 2'b01};
      q_mag = div_sts.quotient[31:0];
   end

   always_comb begin
      state_in    = state_ff;
      sum_in      = sum_ff;
      root_in     = root_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      n_in        = n_ff;
      j_in        = j_ff;
      comp_in     = comp_ff;
      dup_in      = dup_ff;
      busy_div_in = busy_div_ff;
      prod_in     = prod_ff;
      neg_in      = neg_ff;
      for (int i = 0; i < 5; i++) ipt_in[i] = ipt_ff[i];
      mul_a       = mag_d;
      mul_b       = mag_d;
      div_cmd     = '0;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      rsp_tuser   = 1'b0;
      rsp_tlast   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            if (req_tvalid) begin
               if (req_tuser || !have_prev_ff || spacing_ff == 32'd0)
                  state_in = ST_EMIT_LAST;
               else
                  state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            // step_ff: 0 issue, 1 wait, 2 accumulate
            if (step_ff == 6'd0) begin
               step_in = 6'd1;
            end else if (step_ff == 6'd1) begin
               step_in = 6'd2;
            end else begin
               sum_in  = sum_ff + SqWidth'(mul_ff);
               step_in = 6'd0;
               if (comp_ff == 3'd2) begin
                  comp_in  = 3'd0;
                  root_in  = '0;
                  rem_in   = '0;
                  step_in  = 6'(RootSteps - 1);
                  state_in = ST_ROOT;
               end else begin
                  comp_in = comp_ff + 3'd1;
               end
            end
         end
         ST_ROOT: begin
            sum_in = sum_ff << 2;
            if (rem_shift >= root_trial) begin
               rem_in  = rem_shift - root_trial;
               root_in = {root_ff[RootWidth-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               root_in = {root_ff[RootWidth-2:0], 1'b0};
            end
            if (step_ff == 6'd0) begin
               state_in = ST_COUNT;
               busy_div_in = 1'b0;
            end else begin
               step_in = step_ff - 6'd1;
            end
         end
         ST_COUNT: begin
            if (root_ff <= 36'(spacing_ff)) begin
               state_in = ST_EMIT_LAST;
            end else if (!busy_div_ff) begin
               div_cmd.start    = 1'b1;
               div_cmd.dividend = ProdWidth'(root_ff);
               div_cmd.divisor  = ProdWidth'(spacing_ff);
               div_cmd.steps    = 6'(DivStepsN);
               busy_div_in      = 1'b1;
            end else if (div_sts.done) begin
               busy_div_in = 1'b0;
               if (div_sts.quotient > ProdWidth'(MaxInserted))
                  n_in = CntW'(MaxInserted + 1);
               else
                  n_in = CntW'(div_sts.quotient) + CntW'(1);
               j_in     = CntW'(1);
               comp_in  = 3'd0;
               step_in  = 6'd0;
               state_in = ST_LERP_MUL;
            end
         end
         ST_LERP_MUL: begin
            mul_a = mag_d;
            mul_b = 33'(j_ff);
            if (step_ff == 6'd0) begin
               step_in = 6'd1;
            end else begin
               prod_in  = ProdWidth'(mul_ff);
               neg_in   = diff[DiffWidth-1];
               step_in  = 6'd0;
               state_in = ST_LERP_DIV;
            end
         end
         ST_LERP_DIV: begin
            if (!busy_div_ff) begin
               div_cmd.start    = 1'b1;
               div_cmd.dividend = prod_ff;
               div_cmd.divisor  = ProdWidth'(n_ff);
               div_cmd.steps    = 6'(DivStepsLerp);
               busy_div_in      = 1'b1;
            end else if (div_sts.done) begin
               busy_div_in = 1'b0;
               // truncation toward zero: negate the magnitude quotient
               ipt_in[comp_ff] = prev_ff[comp_ff] + (neg_ff ? -q_mag : q_mag);
               if (comp_ff == 3'd4) begin
                  comp_in  = 3'd0;
                  dup_in   = 1'b0;
                  state_in = ST_EMIT_INS;
               end else begin
                  comp_in  = comp_ff + 3'd1;
                  state_in = ST_LERP_MUL;
               end
            end
         end
         ST_EMIT_INS: begin
            rsp_tvalid = 1'b1;
            rsp_tuser  = 1'b1;
            if (rsp_tready) begin
               if (!dup_ff) begin
                  dup_in = 1'b1;
               end else if (j_ff == n_ff - CntW'(1)) begin
                  state_in = ST_EMIT_LAST;
               end else begin
                  j_in     = j_ff + CntW'(1);
                  state_in = ST_LERP_MUL;
               end
            end
         end
         ST_EMIT_LAST: begin
            rsp_tvalid = 1'b1;
            rsp_tlast  = 1'b1;
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_tdata = '0;
      if (state_ff == ST_EMIT_INS) begin
         rsp_tdata[159:0] = {ipt_ff[4], ipt_ff[3], ipt_ff[2], ipt_ff[1], ipt_ff[0]};
      end else begin
         rsp_tdata[159:0] = {cur_ff[4], cur_ff[3], cur_ff[2], cur_ff[1], cur_ff[0]};
      end
      rsp_tdata[191:160] = cell_ff;
      rsp_tdata[RspPayloadWidth-1:192] = face_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         spacing_ff   <= '0;
         have_prev_ff <= 1'b0;
         busy_div_ff  <= 1'b0;
         for (int i = 0; i < 5; i++) cur_ff[i] <= '0;
      end else begin
         state_ff    <= state_in;
         busy_div_ff <= busy_div_in;
         if (csr_wr_en) spacing_ff <= csr_wr_data;
         if (req_tvalid && req_tready) begin
            for (int i = 0; i < 5; i++) cur_ff[i] <= req_tdata[32*i +: 32];
            have_prev_ff <= 1'b1;
         end
      end
      // previous point is the point accepted before the current one
      if (reset) begin
         for (int i = 0; i < 5; i++) prev_ff[i] <= '0;
      end else if (req_tvalid && req_tready) begin
         for (int i = 0; i < 5; i++) prev_ff[i] <= cur_ff[i];
      end
      if (req_tvalid && req_tready) begin
         cell_ff <= req_tdata[191:160];
         face_ff <= req_tdata[194:192];
      end
      if (req_tvalid && req_tready) begin
         sum_ff  <= '0;
         comp_ff <= 3'd0;
         step_ff <= 6'd0;
      end else begin
         sum_ff  <= sum_in;
         comp_ff <= comp_in;
         step_ff <= step_in;
      end
      root_ff <= root_in;
      rem_ff  <= rem_in;
      n_ff    <= n_in;
      j_ff    <= j_in;
      dup_ff  <= dup_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      for (int i = 0; i < 5; i++) ipt_ff[i] <= ipt_in[i];
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("request taken while busy");
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed under stall");
   a_last_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (state_ff == ST_IDLE))
      else $error("run continued after last");

endmodule
